[rtl/refcounted_buffer_pool_macros.svh]
// Assertion helpers, clocked on clk, disabled while arst_n is low.
`ifndef REFCOUNTED_BUFFER_POOL_MACROS_SVH
`define REFCOUNTED_BUFFER_POOL_MACROS_SVH

// same-cycle implication
`define RCBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rcbp_pkg.sv]
`default_nettype none

package rcbp_pkg;

	localparam int unsigned POOL_ENTRIES_DEF = 256;
	localparam int unsigned BUFFER_BYTES_DEF = 2048;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned HEAD_W  = 12;
	localparam int unsigned BYTES_W = 12;

	localparam logic [HEAD_W-1:0]  HEAD_ROOM_RST = 12'd256;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [BYTES_W-1:0] TAIL_MAX      = 12'hFFF;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_ADD_REF  = 2'd2,
		OP_DROP_REF = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] buffer_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   buffer_id;
		status_t            status;
		logic [COUNT_W-1:0] count_after;
		logic               released;
		logic [HEAD_W-1:0]  head_bytes;
		logic [BYTES_W-1:0] tail_bytes;
	} rsp_t;

	typedef logic [HEAD_W-1:0] cfg_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/rcbp_chan_if.sv]
`default_nettype none

interface rcbp_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/rcbp_ctrl.sv]
`default_nettype none

module rcbp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rcbp_pkg::sts_t sts,
	output rcbp_pkg::cmd_t cmd
);
	import rcbp_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_ready  = ready_q;
	assign cmd.load   = req_valid && ready_q;
	assign cmd.commit = (state_q == S_EXEC) && sts.out_free;

endmodule

`default_nettype wire

[rtl/rcbp_dp.sv]
`default_nettype none

module rcbp_dp #(
	parameter int unsigned POOL_ENTRIES = rcbp_pkg::POOL_ENTRIES_DEF,
	parameter int unsigned BUFFER_BYTES = rcbp_pkg::BUFFER_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rcbp_pkg::req_t req_data,
	input  rcbp_pkg::cmd_t cmd,
	output rcbp_pkg::sts_t sts,
	rcbp_chan_if.source    rsp,
	rcbp_chan_if.sink      cfg
);
	import rcbp_pkg::*;

	localparam int unsigned AW = $clog2(POOL_ENTRIES);
	localparam int unsigned GW = AW / 2;
	localparam int unsigned HW = AW - GW;
	localparam int unsigned GS = 2 ** GW;
	localparam int unsigned NG = 2 ** HW;
	localparam int unsigned NP = 2 ** AW;
	localparam int unsigned LW = (GW > 0) ? GW : 1;
	localparam int unsigned TW = 18;

	logic [POOL_ENTRIES-1:0] map_q;
	logic [POOL_ENTRIES-1:0] cnt_vld_q;
	logic [COUNT_W-1:0]      cnt_mem [POOL_ENTRIES];

	logic [NP-1:0] free_vec;
	logic [GS-1:0] grp_vec [NG];
	logic [NG-1:0] grp_free;
	logic [GS-1:0] grp_bits;
	logic [HW-1:0] grp_enc;
	logic [HW-1:0] grp_q;
	logic          any_free_q;
	logic [LW-1:0] lane;
	logic [AW-1:0] slot;

	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COUNT_W-1:0] rd_q;
	logic               rvld_q;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      addr;
	logic               in_range;
	logic [COUNT_W-1:0] cur;

	logic [TW-1:0]      tail_diff;
	logic [BYTES_W-1:0] tail;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [COUNT_W-1:0] mem_wd;
	logic               map_we;
	logic [AW-1:0]      map_wa;
	logic               map_wd;

	logic [HEAD_W-1:0] head_room_q;
	rsp_t              rsp_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// two-level first-free search: groups at load, lane within group at commit
	always_comb begin
		free_vec = '0;
		for (int unsigned i = 0; i < NP; i++) begin
			if (i < POOL_ENTRIES) begin
				free_vec[i] = ~map_q[i];
			end
		end
	end

	always_comb begin
		for (int unsigned g = 0; g < NG; g++) begin
			grp_vec[g]  = free_vec[g*GS +: GS];
			grp_free[g] = |grp_vec[g];
		end
	end

	always_comb begin
		grp_enc = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_free[g]) begin
				grp_enc = HW'(g);
			end
		end
	end

	assign grp_bits = grp_vec[grp_q];

	always_comb begin
		lane = '0;
		for (int l = GS - 1; l >= 0; l--) begin
			if (grp_bits[l]) begin
				lane = LW'(l);
			end
		end
	end

	assign slot     = (AW'(grp_q) << GW) | AW'(lane);
	assign raddr    = AW'(req_data.buffer_index);
	assign addr     = AW'(idx_q);
	assign in_range = 32'(idx_q) < POOL_ENTRIES;
	assign cur      = rvld_q ? rd_q : '0;

	always_comb begin
		if (TW'(head_room_q) >= TW'(BUFFER_BYTES)) begin
			tail_diff = '0;
		end else begin
			tail_diff = TW'(BUFFER_BYTES) - TW'(head_room_q);
		end
		tail = (tail_diff > TW'(TAIL_MAX)) ? TAIL_MAX : tail_diff[BYTES_W-1:0];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr;
		mem_wd = '0;
		map_we = 1'b0;
		map_wa = addr;
		map_wd = 1'b0;
		rsp_d.buffer_id   = idx_q;
		rsp_d.status      = ST_OK;
		rsp_d.count_after = '0;
		rsp_d.released    = 1'b0;
		rsp_d.head_bytes  = '0;
		rsp_d.tail_bytes  = '0;
		case (op_q)
			OP_ALLOC: begin
				if (any_free_q) begin
					mem_we = 1'b1;
					mem_wa = slot;
					mem_wd = COUNT_W'(1);
					map_we = 1'b1;
					map_wa = slot;
					map_wd = 1'b1;
					rsp_d.buffer_id   = IDX_W'(slot);
					rsp_d.count_after = COUNT_W'(1);
					rsp_d.head_bytes  = head_room_q;
					rsp_d.tail_bytes  = tail;
				end else begin
					rsp_d.buffer_id = '0;
					rsp_d.status    = ST_EMPTY;
				end
			end
			OP_FREE: begin
				if (in_range) begin
					map_we = 1'b1;
					rsp_d.count_after = cur;
					rsp_d.released    = map_q[addr];
				end
			end
			OP_ADD_REF: begin
				if (in_range) begin
					if (cur == COUNT_MAX) begin
						rsp_d.status      = ST_SATURATED;
						rsp_d.count_after = COUNT_MAX;
					end else begin
						mem_we = 1'b1;
						mem_wd = cur + COUNT_W'(1);
						rsp_d.count_after = cur + COUNT_W'(1);
					end
				end
			end
			OP_DROP_REF: begin
				if (in_range && (cur != '0)) begin
					mem_we = 1'b1;
					mem_wd = cur - COUNT_W'(1);
					rsp_d.count_after = cur - COUNT_W'(1);
					if (cur == COUNT_W'(1)) begin
						map_we = 1'b1;
						rsp_d.released = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// count store: entries never written read as zero through cnt_vld_q
	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			cnt_mem[mem_wa] <= mem_wd;
		end
		if (cmd.load) begin
			rd_q <= cnt_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= req_data.operation;
			idx_q      <= req_data.buffer_index;
			grp_q      <= grp_enc;
			any_free_q <= |grp_free;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			cnt_vld_q   <= '0;
			rvld_q      <= 1'b0;
			head_room_q <= HEAD_ROOM_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rvld_q <= cnt_vld_q[raddr];
			end
			if (cmd.commit && mem_we) begin
				cnt_vld_q[mem_wa] <= 1'b1;
			end
			if (cmd.commit && map_we) begin
				map_q[map_wa] <= map_wd;
			end
			if (cfg.valid) begin
				head_room_q <= cfg.data;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cfg.ready    = 1'b1;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.data     = rsp_q;
	assign sts.out_free = !rsp_valid_q || rsp.ready;

endmodule

`default_nettype wire

[rtl/refcounted_buffer_pool.sv]
// Reference-counted buffer pool: allocate, free, add and drop reference on a
// pool of POOL_ENTRIES buffers, one result per request. When a request is
// accepted, the count store is read and the group summaries of the in-use map
// are searched; in the execute state, once the result register is free, the
// free slot within the chosen group is found, the count store and map are
// written back and the result register is loaded, so no new request is
// accepted until the last one has loaded its result. The result register frees
// the input side as soon as the result is loaded; a stalled result holds the
// next request in its execute state. Counts live in a single-port-write memory
// with a valid bit per entry, so no clearing pass follows reset. head_room may
// be written at any time the block is idle; it is always ready.
`default_nettype none

module refcounted_buffer_pool #(
	parameter int unsigned POOL_ENTRIES = rcbp_pkg::POOL_ENTRIES_DEF,
	parameter int unsigned BUFFER_BYTES = rcbp_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rcbp_chan_if.sink   req,
	rcbp_chan_if.source rsp,
	rcbp_chan_if.sink   cfg
);
	import rcbp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rcbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcbp_dp #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp),
		.cfg      (cfg)
	);

endmodule

`default_nettype wire

[rtl/rcbp_checker.sv]
`default_nettype none
`include "refcounted_buffer_pool_macros.svh"

module rcbp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input rcbp_pkg::rsp_t                 rsp_data
);
	import rcbp_pkg::*;

	`RCBP_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second transfer while busy")
	`RCBP_ASSERT_NEXT(a_result_follows, !req_ready && !rsp_valid, rsp_valid, "busy with empty result slot but no result")
	`RCBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
	`RCBP_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_data.status == ST_EMPTY), (rsp_data.count_after == '0) && !rsp_data.released && (rsp_data.head_bytes == '0) && (rsp_data.tail_bytes == '0), "empty result not zeroed")
	`RCBP_ASSERT_NOW(a_release_zero, rsp_valid && rsp_data.released && (rsp_data.status != ST_OK), 1'b0, "release with error status")

endmodule

bind refcounted_buffer_pool rcbp_checker u_rcbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
